@@ rtl/obc_pkg.sv @@
// types, constants and angle table for the oriented box corner pipeline
package obc_pkg;

    localparam int CordicSteps   = 16;
    localparam int StepsPerStage = 4;
    localparam int CordicStages  = CordicSteps / StepsPerStage;
    localparam int XyW           = 27;
    localparam int ZW            = 20;
    localparam int ProdW         = 52;
    localparam int SumW          = 53;
    localparam int RndW          = 28;

    localparam logic signed [XyW-1:0] CordicK = 27'sd10188014;
    localparam logic signed [XyW-1:0] OneQ24  = 27'sd16777216;
    localparam logic signed [ZW-1:0]  PiQ16     = 20'sd205887;
    localparam logic signed [ZW-1:0]  HalfPiQ16 = 20'sd102944;
    localparam logic signed [ZW:0]    TwoPiQ16  = 21'sd411775;
    localparam logic signed [SumW-1:0] HalfLsb  = 53'sd16777216;

    typedef enum logic {
        REG_BOX_LENGTH = 1'b0,
        REG_BOX_WIDTH  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] front_left_x;
        logic signed [31:0] front_left_y;
        logic signed [31:0] back_left_x;
        logic signed [31:0] back_left_y;
        logic signed [31:0] back_right_x;
        logic signed [31:0] back_right_y;
        logic signed [31:0] front_right_x;
        logic signed [31:0] front_right_y;
        logic               corners_valid;
    } corners_t;

    // per-item control flags carried down the pipe
    typedef struct packed {
        logic rej;
        logic zero;
        logic neg;
    } flags_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] idx);
        logic signed [ZW-1:0] r;
        begin
            case (idx)
                4'd0:    r = 20'sd51472;
                4'd1:    r = 20'sd30386;
                4'd2:    r = 20'sd16055;
                4'd3:    r = 20'sd8150;
                4'd4:    r = 20'sd4091;
                4'd5:    r = 20'sd2047;
                4'd6:    r = 20'sd1024;
                4'd7:    r = 20'sd512;
                4'd8:    r = 20'sd256;
                4'd9:    r = 20'sd128;
                4'd10:   r = 20'sd64;
                4'd11:   r = 20'sd32;
                4'd12:   r = 20'sd16;
                4'd13:   r = 20'sd8;
                4'd14:   r = 20'sd4;
                default: r = 20'sd2;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v > 33'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -33'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/obc_if.sv @@
// valid/ready channels for poses and corner results
interface obc_pose_if;
    logic           valid;
    logic           ready;
    obc_pkg::pose_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface obc_corners_if;
    logic              valid;
    logic              ready;
    obc_pkg::corners_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/oriented_box_corners_core.sv @@
// the result passes through 9 register stages after the pose transfer
// throughput: one pose per cycle while corners.ready is high; the 16 cordic steps run 4 per stage in 4 stages
// each stage holds its item while the next one is full and cannot move, bubbles are squeezed out
// reset: valid bits clear, box_length = 4.5 m and box_width = 1.8 m in Q16
// the only reset state is the stage valid bits and the two size registers
module oriented_box_corners_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [23:0]            cfg_data,
    obc_pose_if.sink               pose,
    obc_corners_if.source          corners
);

    localparam int NumStages = 9;
    localparam int XyW  = obc_pkg::XyW;
    localparam int ZW   = obc_pkg::ZW;
    localparam int NC   = obc_pkg::CordicStages;
    localparam int SPS  = obc_pkg::StepsPerStage;

    logic [23:0] box_length_reg;
    logic [23:0] box_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg <= 24'd294912;
            box_width_reg  <= 24'd117965;
        end
        else if (cfg_we)
        begin
            case (obc_pkg::cfg_reg_t'(cfg_addr))
                obc_pkg::REG_BOX_LENGTH: box_length_reg <= cfg_data;
                obc_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    logic [NumStages-1:0] vld_reg;
    logic [NumStages:0]   en;

    always_comb
    begin
        en[NumStages] = corners.ready;
        for (int k = NumStages - 1; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign pose.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= pose.valid;
            for (int k = 1; k < NumStages; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 0: angle range reduction
    logic signed [31:0] cx_reg [NumStages-1];
    logic signed [31:0] cy_reg [NumStages-1];
    obc_pkg::flags_t    fl_reg [NumStages-2];
    logic signed [ZW-1:0] z0_reg;

    logic signed [ZW:0]   ang_a;
    logic signed [ZW:0]   ang_b;
    logic signed [ZW-1:0] z0_next;
    obc_pkg::flags_t      fl0_next;

    always_comb
    begin
        ang_a = {pose.data.heading[15], pose.data.heading, 4'd0};
        if (ang_a > (ZW+1)'(obc_pkg::PiQ16))
            ang_a = ang_a - obc_pkg::TwoPiQ16;
        fl0_next.neg = 1'b0;
        ang_b = ang_a;
        if (ang_a > (ZW+1)'(obc_pkg::HalfPiQ16))
        begin
            ang_b = ang_a - (ZW+1)'(obc_pkg::PiQ16);
            fl0_next.neg = 1'b1;
        end
        else if (ang_a < -(ZW+1)'(obc_pkg::HalfPiQ16))
        begin
            ang_b = ang_a + (ZW+1)'(obc_pkg::PiQ16);
            fl0_next.neg = 1'b1;
        end
        z0_next = ang_b[ZW-1:0];
        fl0_next.rej  = pose.data.heading[15];
        fl0_next.zero = (pose.data.heading == 16'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z0_reg    <= z0_next;
            fl_reg[0] <= fl0_next;
            cx_reg[0] <= pose.data.center_x;
            cy_reg[0] <= pose.data.center_y;
        end
    end

    // stages 1..4: cordic rotation, four micro-rotations per stage
    logic signed [XyW-1:0] x_reg [NC];
    logic signed [XyW-1:0] y_reg [NC];
    logic signed [ZW-1:0]  z_reg [NC];

    for (genvar s = 0; s < NC; s++)
    begin : g_cordic
        logic signed [XyW-1:0] x_next;
        logic signed [XyW-1:0] y_next;
        logic signed [ZW-1:0]  z_next;

        always_comb
        begin
            logic signed [XyW-1:0] xs;
            logic signed [XyW-1:0] ys;
            if (s == 0)
            begin
                x_next = obc_pkg::CordicK;
                y_next = '0;
                z_next = z0_reg;
            end
            else
            begin
                x_next = x_reg[s-1];
                y_next = y_reg[s-1];
                z_next = z_reg[s-1];
            end
            for (int j = 0; j < SPS; j++)
            begin
                xs = x_next >>> (s * SPS + j);
                ys = y_next >>> (s * SPS + j);
                if (z_next >= 0)
                begin
                    x_next = x_next - ys;
                    y_next = y_next + xs;
                    z_next = z_next - obc_pkg::atan_q16(4'(s * SPS + j));
                end
                else
                begin
                    x_next = x_next + ys;
                    y_next = y_next - xs;
                    z_next = z_next + obc_pkg::atan_q16(4'(s * SPS + j));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s+1])
            begin
                x_reg[s]    <= x_next;
                y_reg[s]    <= y_next;
                z_reg[s]    <= z_next;
                fl_reg[s+1] <= fl_reg[s];
                cx_reg[s+1] <= cx_reg[s];
                cy_reg[s+1] <= cy_reg[s];
            end
        end
    end

    // stage 5: quadrant sign and the exact zero-heading values
    logic signed [XyW-1:0] cos_reg;
    logic signed [XyW-1:0] sin_reg;

    always_ff @(posedge clk)
    begin
        if (en[NC+1])
        begin
            if (fl_reg[NC].zero)
            begin
                cos_reg <= obc_pkg::OneQ24;
                sin_reg <= '0;
            end
            else if (fl_reg[NC].neg)
            begin
                cos_reg <= -x_reg[NC-1];
                sin_reg <= -y_reg[NC-1];
            end
            else
            begin
                cos_reg <= x_reg[NC-1];
                sin_reg <= y_reg[NC-1];
            end
            fl_reg[NC+1] <= fl_reg[NC];
            cx_reg[NC+1] <= cx_reg[NC];
            cy_reg[NC+1] <= cy_reg[NC];
        end
    end

    // stage 6: four products
    logic signed [obc_pkg::ProdW-1:0] lc_reg, ws_reg, wc_reg, ls_reg;
    logic signed [24:0] len_s;
    logic signed [24:0] wid_s;

    assign len_s = {1'b0, box_length_reg};
    assign wid_s = {1'b0, box_width_reg};

    always_ff @(posedge clk)
    begin
        if (en[NC+2])
        begin
            lc_reg <= len_s * cos_reg;
            ws_reg <= wid_s * sin_reg;
            wc_reg <= wid_s * cos_reg;
            ls_reg <= len_s * sin_reg;
            fl_reg[NC+2] <= fl_reg[NC+1];
            cx_reg[NC+2] <= cx_reg[NC+1];
            cy_reg[NC+2] <= cy_reg[NC+1];
        end
    end

    // stage 7: corner sums, rounded half up to Q16
    localparam int SW = obc_pkg::SumW;
    localparam int RW = obc_pkg::RndW;
    logic signed [RW-1:0] rnd_reg [8];
    logic signed [SW-1:0] sum [8];
    logic rej7_reg;

    always_comb
    begin
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] d;
        a = SW'(lc_reg);
        b = SW'(ws_reg);
        c = SW'(wc_reg);
        d = SW'(ls_reg);
        sum[0] =  a - b;
        sum[1] =  c + d;
        sum[2] = -a - b;
        sum[3] =  c - d;
        sum[4] = -a + b;
        sum[5] = -c - d;
        sum[6] =  a + b;
        sum[7] = -c + d;
    end

    for (genvar q = 0; q < 8; q++)
    begin : g_round
        logic signed [SW-1:0] rs;
        assign rs = (sum[q] + obc_pkg::HalfLsb) >>> 25;
        always_ff @(posedge clk)
        begin
            if (en[NC+3])
                rnd_reg[q] <= rs[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NC+3])
        begin
            rej7_reg     <= fl_reg[NC+2].rej;
            cx_reg[NC+3] <= cx_reg[NC+2];
            cy_reg[NC+3] <= cy_reg[NC+2];
        end
    end

    // stage 8: add the center, saturate, zero on rejected heading
    obc_pkg::corners_t out_reg;
    obc_pkg::corners_t out_next;
    logic signed [31:0] sat_v [8];

    for (genvar q = 0; q < 8; q++)
    begin : g_sat
        logic signed [32:0] cen;
        assign cen = (q % 2 == 0) ? 33'(cx_reg[NC+3]) : 33'(cy_reg[NC+3]);
        assign sat_v[q] = obc_pkg::sat32(cen + 33'(rnd_reg[q]));
    end

    always_comb
    begin
        out_next.front_left_x  = sat_v[0];
        out_next.front_left_y  = sat_v[1];
        out_next.back_left_x   = sat_v[2];
        out_next.back_left_y   = sat_v[3];
        out_next.back_right_x  = sat_v[4];
        out_next.back_right_y  = sat_v[5];
        out_next.front_right_x = sat_v[6];
        out_next.front_right_y = sat_v[7];
        out_next.corners_valid = 1'b1;
        if (rej7_reg)
            out_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[NumStages-1])
            out_reg <= out_next;
    end

    assign corners.valid = vld_reg[NumStages-1];
    assign corners.data  = out_reg;

    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        corners.valid && !corners.data.corners_valid |->
            corners.data.front_left_x == 32'sd0 && corners.data.back_right_y == 32'sd0)
        else $error("rejected result carries nonzero corners");

    a_zero_cos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NC+1] && fl_reg[NC+1].zero |-> cos_reg == obc_pkg::OneQ24 && sin_reg == '0)
        else $error("zero heading lost its exact sine and cosine");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NumStages-2] && !en[NumStages-2] |=> vld_reg[NumStages-2])
        else $error("stalled stage dropped its item");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en[NC+1] |-> vld_reg[NC+1] && vld_reg[NumStages-1])
        else $error("stall with an empty stage downstream");

endmodule

@@ sim/oriented_box_corners_core_tb.sv @@
// testbench for the oriented box corner pipeline: directed and random poses, checked per field
module oriented_box_corners_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 9;
    localparam int WatchdogLimit = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [23:0] cfg_data = '0;

    obc_pose_if    pose_ch ();
    obc_corners_if corner_ch ();

    oriented_box_corners_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .pose    (pose_ch.sink),
        .corners (corner_ch.source)
    );

    always #10 clk = ~clk;

    logic [23:0] len_q16 = 24'd294912;
    logic [23:0] wid_q16 = 24'd117965;
    obc_pkg::corners_t expected_corners[$];
    int errors = 0;
    int poses_sent = 0;
    int results_seen = 0;
    int rejected_seen = 0;
    int idle_pct = 17;
    int idle_cycles = 0;

    initial
    begin
        pose_ch.valid = 1'b0;
        pose_ch.data = '0;
        corner_ch.ready = 1'b0;
    end

    function automatic void rotate_sin_cos(longint ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        longint steps[16];
        x = 10188014;
        y = 0;
        flip = 0;
        steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2};
        if (ang > 205887)
            ang -= 411775;
        if (ang > 102944)
        begin
            ang -= 205887;
            flip = 1;
        end
        else if (ang < -102944)
        begin
            ang += 205887;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z -= steps[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z += steps[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [31:0] corner_coord(longint a2, longint b2, longint c,
                                                         longint s, longint centre, bit is_y);
        longint p, v;
        p = is_y ? (b2 * c + a2 * s) : (a2 * c - b2 * s);
        v = centre + ((p + 64'sd16777216) >>> 25);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic obc_pkg::corners_t predict_corners(obc_pkg::pose_t p);
        obc_pkg::corners_t r;
        longint cx, cy, hd, l, w, c, s;
        r = '0;
        cx = longint'(p.center_x);
        cy = longint'(p.center_y);
        hd = longint'(p.heading);
        l = longint'(len_q16);
        w = longint'(wid_q16);
        if (hd < 0)
            return r;
        if (hd == 0)
        begin
            c = 16777216;
            s = 0;
        end
        else
            rotate_sin_cos(hd * 16, c, s);
        r.front_left_x  = corner_coord(l, w, c, s, cx, 0);
        r.front_left_y  = corner_coord(l, w, c, s, cy, 1);
        r.back_left_x   = corner_coord(-l, w, c, s, cx, 0);
        r.back_left_y   = corner_coord(-l, w, c, s, cy, 1);
        r.back_right_x  = corner_coord(-l, -w, c, s, cx, 0);
        r.back_right_y  = corner_coord(-l, -w, c, s, cy, 1);
        r.front_right_x = corner_coord(l, -w, c, s, cx, 0);
        r.front_right_y = corner_coord(l, -w, c, s, cy, 1);
        r.corners_valid = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(string what, logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // result checker and random sink stall
    always @(posedge clk)
    begin
        obc_pkg::corners_t got, want;
        if (rst_n && corner_ch.valid && corner_ch.ready)
        begin
            got = corner_ch.data;
            results_seen++;
            if (!got.corners_valid)
                rejected_seen++;
            if (expected_corners.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                want = expected_corners.pop_front();
                check_field("front_left_x", got.front_left_x, want.front_left_x);
                check_field("front_left_y", got.front_left_y, want.front_left_y);
                check_field("back_left_x", got.back_left_x, want.back_left_x);
                check_field("back_left_y", got.back_left_y, want.back_left_y);
                check_field("back_right_x", got.back_right_x, want.back_right_x);
                check_field("back_right_y", got.back_right_y, want.back_right_y);
                check_field("front_right_x", got.front_right_x, want.front_right_x);
                check_field("front_right_y", got.front_right_y, want.front_right_y);
                if (got.corners_valid !== want.corners_valid)
                    report_mismatch("corners_valid", got.corners_valid, want.corners_valid);
            end
        end
    end

    always @(negedge clk)
        corner_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((pose_ch.valid && pose_ch.ready) || (corner_ch.valid && corner_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // valid stays up after a transfer; the next call or drain_pipe sets it
    task automatic send_pose(logic signed [31:0] cx, logic signed [31:0] cy,
                             logic signed [15:0] hd);
        obc_pkg::pose_t p;
        p.center_x = cx;
        p.center_y = cy;
        p.heading = hd;
        while ($urandom_range(99) < idle_pct)
        begin
            pose_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pose_ch.valid <= 1'b1;
        pose_ch.data <= p;
        @(posedge clk);
        while (!pose_ch.ready)
            @(posedge clk);
        expected_corners = {expected_corners, predict_corners(p)};
        poses_sent++;
        @(negedge clk);
    endtask

    task automatic write_size(obc_pkg::cfg_reg_t idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == obc_pkg::REG_BOX_LENGTH)
            len_q16 = val;
        else
            wid_q16 = val;
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        pose_ch.valid <= 1'b0;
        while (expected_corners.size() != 0)
            @(negedge clk);
        repeat (Latency + 2) @(negedge clk);
    endtask

    task automatic test_directed_poses();
        send_pose(32'sd0, 32'sd0, 16'sd0);
        send_pose(32'sh7fffffff, 32'sh7fffffff, 16'sd0);
        send_pose(32'sh80000000, 32'sh80000000, 16'sd0);
        send_pose(32'sd65536, -32'sd65536, 16'sd1);
        send_pose(32'sd0, 32'sd0, 16'sd6434);
        send_pose(32'sd0, 32'sd0, 16'sd12868);
        send_pose(32'sd0, 32'sd0, 16'sd19302);
        send_pose(32'sd0, 32'sd0, 16'sd25736);
        send_pose(32'sd0, 32'sd0, 16'sd6433);
        send_pose(32'sd0, 32'sd0, 16'sd12869);
        send_pose(32'sh7fffff00, 32'sh80000100, 16'sd32767);
        send_pose(32'sh80000100, 32'sh7fffff00, 16'sd16000);
        send_pose(32'sd12345, 32'sd678, -16'sd1);
        send_pose(32'sh7fffffff, 32'sh80000000, -16'sd32768);
        send_pose(32'sd1000, 32'sd2000, 16'sd3000);
    endtask

    task automatic test_size_extremes();
        drain_pipe();
        write_size(obc_pkg::REG_BOX_LENGTH, 24'hffffff);
        write_size(obc_pkg::REG_BOX_WIDTH, 24'hffffff);
        send_pose(32'sh7fff0000, 32'sh80010000, 16'sd0);
        send_pose(32'sh7fff0000, 32'sh7fff0000, 16'sd3217);
        send_pose(32'sh80010000, 32'sh80010000, 16'sd9651);
        drain_pipe();
        write_size(obc_pkg::REG_BOX_LENGTH, 24'd0);
        write_size(obc_pkg::REG_BOX_WIDTH, 24'd0);
        send_pose(32'sd77, -32'sd77, 16'sd5000);
        drain_pipe();
        write_size(obc_pkg::REG_BOX_LENGTH, 24'd3);
        write_size(obc_pkg::REG_BOX_WIDTH, 24'd1);
        send_pose(32'sd0, 32'sd0, 16'sd0);
        send_pose(-32'sd5, 32'sd5, 16'sd2000);
    endtask

    task automatic send_random_poses(int n);
        logic [15:0] hd;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: hd = 16'($urandom) | 16'h8000;
                1: hd = 16'd0;
                2: hd = 16'($urandom_range(32767, 32000));
                default: hd = 16'($urandom_range(32767));
            endcase
            if ($urandom_range(3) == 0)
                send_pose($urandom, $urandom, hd);
            else
                send_pose(32'($signed($urandom_range(20000000)) - 10000000),
                          32'($signed($urandom_range(20000000)) - 10000000), hd);
        end
    endtask

    task automatic test_random_sizes();
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_pipe();
            write_size(obc_pkg::REG_BOX_LENGTH, 24'($urandom));
            write_size(obc_pkg::REG_BOX_WIDTH,
                       (phase % 2) ? 24'($urandom) : 24'($urandom_range(400000)));
            idle_pct = (phase == 3) ? 0 : 17;
            send_random_poses(270);
        end
        idle_pct = 17;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_poses();
        test_size_extremes();
        test_random_sizes();
        drain_pipe();
        $display("covered %0d poses, %0d results (%0d rejected headings), several box sizes",
                 poses_sent, results_seen, rejected_seen);
        if (errors == 0 && expected_corners.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/obc_pkg.sv
rtl/obc_if.sv
rtl/oriented_box_corners_core.sv
sim/oriented_box_corners_core_tb.sv
